// File: design/space_time_grid_successor_expander_unit_macros.svh
// assertion macros used by the successor expander sequencer
`ifndef SPACE_TIME_GRID_SUCCESSOR_EXPANDER_UNIT_MACROS_SVH
`define SPACE_TIME_GRID_SUCCESSOR_EXPANDER_UNIT_MACROS_SVH

// general form: explicit clock and active-low reset
`define STGSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// short form for modules with the usual i_clk / i_rst_n ports
`define STGSE_ASSERT_STD(lbl, prop, msg) \
    `STGSE_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: design/stgse_pkg.sv
// types, codes and constants of the space-time successor expander
`timescale 1ns / 1ps
`default_nettype none

package stgse_pkg;

    localparam int GRID_SIDE_DEF  = 16;
    localparam int MAX_PATHS_DEF  = 8;
    localparam int PATH_DEPTH_DEF = 64;
    localparam int WINDOW_DEF     = 1;

    localparam logic [9:0] TIME_MAX = 10'd1023;

    // command codes
    localparam logic [1:0] CMD_OBS    = 2'd0;
    localparam logic [1:0] CMD_PATH   = 2'd1;
    localparam logic [1:0] CMD_EXPAND = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_GOAL_X = 3'd3;
    localparam logic [2:0] REG_GOAL_Y = 3'd4;
    localparam logic [2:0] REG_GOAL_Z = 3'd5;
    localparam logic [2:0] REG_MOVE   = 3'd6;
    localparam logic [2:0] REG_HOVER  = 3'd7;

    // candidate moves in trial order
    localparam logic [2:0] MV_XN    = 3'd0;
    localparam logic [2:0] MV_XP    = 3'd1;
    localparam logic [2:0] MV_YN    = 3'd2;
    localparam logic [2:0] MV_YP    = 3'd3;
    localparam logic [2:0] MV_ZN    = 3'd4;
    localparam logic [2:0] MV_ZP    = 3'd5;
    localparam logic [2:0] MV_HOVER = 3'd6;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [3:0] cell_z;
        logic [9:0] step_time;
        logic       blocked_bit;
        logic [2:0] path_select;
        logic       final_point;
    } t_cmd_item;

    typedef struct packed {
        logic       valid_res;
        logic [3:0] next_x;
        logic [3:0] next_y;
        logic [3:0] next_z;
        logic [9:0] next_time;
        logic [7:0] edge_cost;
        logic [5:0] estimate;
        logic       reaches_goal;
        logic       last;
    } t_res_item;

    typedef struct packed {
        logic [4:0] size_x;
        logic [4:0] size_y;
        logic [4:0] size_z;
        logic [3:0] goal_x;
        logic [3:0] goal_y;
        logic [3:0] goal_z;
        logic [7:0] move_cost;
        logic [7:0] hover_cost;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
    } t_obs_rd;

    typedef struct packed {
        logic       en;
        logic [4:0] path;
        logic [9:0] index;
    } t_path_rd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GOAL,
        ST_CAND,
        ST_SCAN,
        ST_FIN,
        ST_EMIT
    } t_seq_state;

    function automatic logic [3:0] abs_diff4(input logic [3:0] a, input logic [3:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// File: design/stgse_obs_mem.sv
// obstacle bit memory with clearing sweep after reset
`timescale 1ns / 1ps
`default_nettype none

module stgse_obs_mem #(
    parameter int GRID_SIDE = stgse_pkg::GRID_SIDE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire stgse_pkg::t_cmd_item i_wr_item,
    input  wire stgse_pkg::t_obs_rd i_rd,
    output logic                    o_rd_bit,
    output logic                    o_clr_busy
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic          mem [DEPTH];
    logic [AW-1:0] r_clr_cnt;
    logic          r_clr_busy;
    logic          r_rd_bit;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_in_grid;

    assign wr_in_grid = (32'(i_wr_item.cell_x) < GRID_SIDE) &&
                        (32'(i_wr_item.cell_y) < GRID_SIDE) &&
                        (32'(i_wr_item.cell_z) < GRID_SIDE);
    assign wr_addr = AW'((32'(i_wr_item.cell_x) * GRID_SIDE + 32'(i_wr_item.cell_y))
                         * GRID_SIDE + 32'(i_wr_item.cell_z));
    assign rd_addr = AW'((32'(i_rd.x) * GRID_SIDE + 32'(i_rd.y)) * GRID_SIDE + 32'(i_rd.z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
            if (r_clr_cnt == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_cnt] <= 1'b0;
        end else if (i_wr_en && wr_in_grid) begin
            mem[wr_addr] <= i_wr_item.blocked_bit;
        end
        if (i_rd.en) begin
            r_rd_bit <= mem[rd_addr];
        end
    end

    assign o_rd_bit   = r_rd_bit;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// File: design/stgse_path_store.sv
// path point memory and per-path length registers
`timescale 1ns / 1ps
`default_nettype none

module stgse_path_store #(
    parameter int MAX_PATHS  = stgse_pkg::MAX_PATHS_DEF,
    parameter int PATH_DEPTH = stgse_pkg::PATH_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire stgse_pkg::t_cmd_item i_wr_item,
    input  wire stgse_pkg::t_path_rd  i_rd,
    input  wire logic [4:0]           i_len_path,
    output logic [11:0]               o_rd_point,
    output logic [10:0]               o_len
);

    localparam int P_W   = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
    localparam int L_W   = $clog2(PATH_DEPTH + 1);
    localparam int DEPTH = MAX_PATHS * PATH_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [11:0]    mem [DEPTH];
    logic [L_W-1:0] r_len [MAX_PATHS];
    logic [11:0]    r_rd_point;
    logic           wr_ok;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign wr_ok   = i_wr_en && (32'(i_wr_item.path_select) < MAX_PATHS) &&
                     (32'(i_wr_item.step_time) < PATH_DEPTH);
    assign wr_addr = AW'(32'(i_wr_item.path_select) * PATH_DEPTH + 32'(i_wr_item.step_time));
    assign rd_addr = AW'(32'(i_rd.path) * PATH_DEPTH + 32'(i_rd.index));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PATHS; i++) begin
                r_len[i] <= '0;
            end
        end else if (wr_ok && i_wr_item.final_point) begin
            r_len[P_W'(i_wr_item.path_select)] <= L_W'(i_wr_item.step_time) + L_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= {i_wr_item.cell_x, i_wr_item.cell_y, i_wr_item.cell_z};
        end
        if (i_rd.en) begin
            r_rd_point <= mem[rd_addr];
        end
    end

    assign o_rd_point = r_rd_point;
    assign o_len      = 11'(r_len[i_len_path[P_W-1:0]]);

endmodule

`default_nettype wire

// File: design/stgse_expand_ctl.sv
// expansion sequencer: goal scan, candidate checks, result emission
`timescale 1ns / 1ps
`default_nettype none
`include "space_time_grid_successor_expander_unit_macros.svh"

module stgse_expand_ctl #(
    parameter int GRID_SIDE  = stgse_pkg::GRID_SIDE_DEF,
    parameter int MAX_PATHS  = stgse_pkg::MAX_PATHS_DEF,
    parameter int PATH_DEPTH = stgse_pkg::PATH_DEPTH_DEF,
    parameter int WINDOW     = stgse_pkg::WINDOW_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start_exp,
    input  wire stgse_pkg::t_cmd_item i_item,
    input  wire stgse_pkg::t_cfg      i_cfg,
    input  wire logic                 i_obs_bit,
    input  wire logic [11:0]          i_point,
    input  wire logic [10:0]          i_len,
    output stgse_pkg::t_obs_rd        o_obs_rd,
    output stgse_pkg::t_path_rd       o_path_rd,
    output logic [4:0]                o_len_path,
    output logic                      o_busy,
    output logic                      o_res_valid,
    output stgse_pkg::t_res_item      o_res
);

    localparam int SPAN    = 2 * WINDOW + 1;
    localparam int WW      = $clog2(SPAN + 1);
    localparam int LIM_CAP = (GRID_SIDE < 16) ? GRID_SIDE : 16;

    stgse_pkg::t_seq_state r_state, n_state;
    logic [3:0]  r_x, r_y, r_z;
    logic [9:0]  r_nt, n_nt;
    logic [2:0]  r_k, n_k;
    logic [4:0]  r_p, n_p;
    logic [WW-1:0] r_w, n_w;
    logic [10:0] r_t, n_t;
    logic [6:0]  r_kept, n_kept;
    logic        r_hit, n_hit;
    logic        r_goal_hit, n_goal_hit;
    logic        r_rd_vld, r_rd_goal, r_obs_pend, n_obs_pend;
    logic        r_res_valid, n_res_valid;
    stgse_pkg::t_res_item r_res, n_res;

    logic [4:0]  lim_x, lim_y, lim_z;
    logic [4:0]  sx, sy, sz;
    logic        under, in_range;
    logic [11:0] cand_key, goal_key;
    logic [10:0] tt_off, t_abs, t_idx;
    logic        w_ok, win_rd_en, g_rd_en, pt_match, hit_now;
    logic        p_last, w_last, k_last, kept_last;
    logic [3:0]  ax, ay, az;

    assign lim_x = (i_cfg.size_x > 5'(LIM_CAP)) ? 5'(LIM_CAP) : i_cfg.size_x;
    assign lim_y = (i_cfg.size_y > 5'(LIM_CAP)) ? 5'(LIM_CAP) : i_cfg.size_y;
    assign lim_z = (i_cfg.size_z > 5'(LIM_CAP)) ? 5'(LIM_CAP) : i_cfg.size_z;

    always_comb begin
        sx    = {1'b0, r_x};
        sy    = {1'b0, r_y};
        sz    = {1'b0, r_z};
        under = 1'b0;
        unique case (r_k)
            stgse_pkg::MV_XN: begin
                under = (r_x == 4'd0);
                sx    = {1'b0, r_x} - 5'd1;
            end
            stgse_pkg::MV_XP: sx = {1'b0, r_x} + 5'd1;
            stgse_pkg::MV_YN: begin
                under = (r_y == 4'd0);
                sy    = {1'b0, r_y} - 5'd1;
            end
            stgse_pkg::MV_YP: sy = {1'b0, r_y} + 5'd1;
            stgse_pkg::MV_ZN: begin
                under = (r_z == 4'd0);
                sz    = {1'b0, r_z} - 5'd1;
            end
            stgse_pkg::MV_ZP: sz = {1'b0, r_z} + 5'd1;
            stgse_pkg::MV_HOVER: ;
            default: under = 1'b1;
        endcase
    end

    assign in_range = !under && (sx < lim_x) && (sy < lim_y) && (sz < lim_z);
    assign cand_key = {sx[3:0], sy[3:0], sz[3:0]};
    assign goal_key = {i_cfg.goal_x, i_cfg.goal_y, i_cfg.goal_z};

    // window point index, clamped to the last point of a finished path
    assign tt_off = 11'(r_nt) + 11'(r_w);
    assign w_ok   = tt_off >= 11'(WINDOW);
    assign t_abs  = tt_off - 11'(WINDOW);
    assign t_idx  = (t_abs < i_len) ? t_abs : (i_len - 11'd1);

    assign win_rd_en = (r_state == stgse_pkg::ST_SCAN) && w_ok && (i_len != 11'd0);
    assign g_rd_en   = (r_state == stgse_pkg::ST_GOAL) && (r_t < i_len);

    assign o_len_path      = r_p;
    assign o_path_rd.en    = win_rd_en || g_rd_en;
    assign o_path_rd.path  = r_p;
    assign o_path_rd.index = (r_state == stgse_pkg::ST_GOAL) ? 10'(r_t) : 10'(t_idx);

    assign o_obs_rd.en = (r_state == stgse_pkg::ST_CAND) && in_range;
    assign o_obs_rd.x  = sx[3:0];
    assign o_obs_rd.y  = sy[3:0];
    assign o_obs_rd.z  = sz[3:0];

    assign pt_match = r_rd_vld && (i_point == (r_rd_goal ? goal_key : cand_key));
    assign hit_now  = r_hit || (pt_match && !r_rd_goal) || (r_obs_pend && i_obs_bit);

    assign p_last    = (r_p == 5'(MAX_PATHS - 1));
    assign w_last    = (r_w == WW'(SPAN - 1));
    assign k_last    = (r_k == stgse_pkg::MV_HOVER);
    assign kept_last = ((r_kept >> r_k) >> 1) == 7'd0;

    assign ax = stgse_pkg::abs_diff4(sx[3:0], i_cfg.goal_x);
    assign ay = stgse_pkg::abs_diff4(sy[3:0], i_cfg.goal_y);
    assign az = stgse_pkg::abs_diff4(sz[3:0], i_cfg.goal_z);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stgse_pkg::ST_IDLE: if (i_start_exp) n_state = stgse_pkg::ST_GOAL;
            stgse_pkg::ST_GOAL: if (!g_rd_en && p_last) n_state = stgse_pkg::ST_CAND;
            stgse_pkg::ST_CAND: begin
                if (in_range) begin
                    n_state = stgse_pkg::ST_SCAN;
                end else if (k_last) begin
                    n_state = stgse_pkg::ST_EMIT;
                end
            end
            stgse_pkg::ST_SCAN: if (w_last && p_last) n_state = stgse_pkg::ST_FIN;
            stgse_pkg::ST_FIN:  n_state = k_last ? stgse_pkg::ST_EMIT : stgse_pkg::ST_CAND;
            stgse_pkg::ST_EMIT: begin
                if (r_kept == 7'd0 || (r_kept[r_k] && kept_last)) begin
                    n_state = stgse_pkg::ST_IDLE;
                end
            end
            default: n_state = stgse_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_nt        = r_nt;
        n_k         = r_k;
        n_p         = r_p;
        n_w         = r_w;
        n_t         = r_t;
        n_kept      = r_kept;
        n_hit       = r_hit;
        n_obs_pend  = 1'b0;
        n_goal_hit  = r_goal_hit || (pt_match && r_rd_goal);
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            stgse_pkg::ST_IDLE: begin
                n_nt       = (i_item.step_time == stgse_pkg::TIME_MAX) ?
                             stgse_pkg::TIME_MAX : (i_item.step_time + 10'd1);
                n_t        = 11'(n_nt);
                n_p        = 5'd0;
                n_goal_hit = 1'b0;
            end
            stgse_pkg::ST_GOAL: begin
                if (g_rd_en) begin
                    n_t = r_t + 11'd1;
                end else begin
                    n_t = 11'(r_nt);
                    n_p = p_last ? 5'd0 : (r_p + 5'd1);
                    n_k = stgse_pkg::MV_XN;
                end
            end
            stgse_pkg::ST_CAND: begin
                n_p        = 5'd0;
                n_w        = '0;
                n_hit      = 1'b0;
                n_obs_pend = in_range;
                if (!in_range) begin
                    n_kept[r_k] = 1'b0;
                    n_k         = k_last ? stgse_pkg::MV_XN : (r_k + 3'd1);
                end
            end
            stgse_pkg::ST_SCAN: begin
                n_hit = hit_now;
                if (w_last) begin
                    n_w = '0;
                    n_p = p_last ? r_p : (r_p + 5'd1);
                end else begin
                    n_w = r_w + WW'(1);
                end
            end
            stgse_pkg::ST_FIN: begin
                n_kept[r_k] = !hit_now;
                n_k         = k_last ? stgse_pkg::MV_XN : (r_k + 3'd1);
            end
            stgse_pkg::ST_EMIT: begin
                n_k = r_k + 3'd1;
                if (r_kept == 7'd0) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    n_res.last  = 1'b1;
                end else if (r_kept[r_k]) begin
                    n_res_valid        = 1'b1;
                    n_res.valid_res    = 1'b1;
                    n_res.next_x       = sx[3:0];
                    n_res.next_y       = sy[3:0];
                    n_res.next_z       = sz[3:0];
                    n_res.next_time    = r_nt;
                    n_res.edge_cost    = k_last ? i_cfg.hover_cost : i_cfg.move_cost;
                    n_res.estimate     = 6'(ax) + 6'(ay) + 6'(az);
                    n_res.reaches_goal = (cand_key == goal_key) && !r_goal_hit;
                    n_res.last         = kept_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stgse_pkg::ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_obs_pend  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= o_path_rd.en;
            r_obs_pend  <= n_obs_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == stgse_pkg::ST_IDLE && i_start_exp) begin
            r_x <= i_item.cell_x;
            r_y <= i_item.cell_y;
            r_z <= i_item.cell_z;
        end
        r_nt       <= n_nt;
        r_k        <= n_k;
        r_p        <= n_p;
        r_w        <= n_w;
        r_t        <= n_t;
        r_kept     <= n_kept;
        r_hit      <= n_hit;
        r_goal_hit <= n_goal_hit;
        r_rd_goal  <= (r_state == stgse_pkg::ST_GOAL);
        r_res      <= n_res;
    end

    assign o_busy      = (r_state != stgse_pkg::ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `STGSE_ASSERT_STD(a_strobe_from_emit, r_res_valid |-> $past(r_state == stgse_pkg::ST_EMIT), "result strobe without emit phase")
    `STGSE_ASSERT_STD(a_empty_is_last, (r_res_valid && !r_res.valid_res) |-> r_res.last, "empty expansion result not marked last")
    `STGSE_ASSERT(a_scan_cand_ok, i_clk, i_rst_n, (r_state == stgse_pkg::ST_SCAN || r_state == stgse_pkg::ST_FIN) |-> (r_k <= stgse_pkg::MV_HOVER), "candidate index out of range during scan")

endmodule

`default_nettype wire

// File: design/space_time_grid_successor_expander_unit.sv
// top level of the space-time grid successor expander
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------
//  command   | in        | start & !busy             | i_cmd (t_cmd_item)
//  result    | out       | o_res_valid, one cycle    | o_res (t_res_item)
//  config    | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// an expand first reads the goal-path points of each path (one read per point from
// the next time to each path end), then checks each candidate in turn and scans the
// window of every path for each in-range candidate through the single path-memory
// read port, then emits the results. after reset the obstacle memory is swept
// clear with busy high. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module space_time_grid_successor_expander_unit #(
    parameter int GRID_SIDE  = stgse_pkg::GRID_SIDE_DEF,
    parameter int MAX_PATHS  = stgse_pkg::MAX_PATHS_DEF,
    parameter int PATH_DEPTH = stgse_pkg::PATH_DEPTH_DEF,
    parameter int WINDOW     = stgse_pkg::WINDOW_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire stgse_pkg::t_cmd_item i_cmd,
    output logic                      o_res_valid,
    output stgse_pkg::t_res_item      o_res,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    stgse_pkg::t_cfg     r_cfg;
    stgse_pkg::t_obs_rd  obs_rd;
    stgse_pkg::t_path_rd path_rd;
    logic        accept;
    logic        obs_bit, clr_busy, seq_busy;
    logic [11:0] point;
    logic [10:0] len;
    logic [4:0]  len_path;

    assign accept      = start && !busy;
    assign busy        = clr_busy || seq_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x     <= 5'd16;
            r_cfg.size_y     <= 5'd16;
            r_cfg.size_z     <= 5'd16;
            r_cfg.goal_x     <= 4'd0;
            r_cfg.goal_y     <= 4'd0;
            r_cfg.goal_z     <= 4'd0;
            r_cfg.move_cost  <= 8'd1;
            r_cfg.hover_cost <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stgse_pkg::REG_SIZE_X: r_cfg.size_x     <= i_cfg_data[4:0];
                stgse_pkg::REG_SIZE_Y: r_cfg.size_y     <= i_cfg_data[4:0];
                stgse_pkg::REG_SIZE_Z: r_cfg.size_z     <= i_cfg_data[4:0];
                stgse_pkg::REG_GOAL_X: r_cfg.goal_x     <= i_cfg_data[3:0];
                stgse_pkg::REG_GOAL_Y: r_cfg.goal_y     <= i_cfg_data[3:0];
                stgse_pkg::REG_GOAL_Z: r_cfg.goal_z     <= i_cfg_data[3:0];
                stgse_pkg::REG_MOVE:   r_cfg.move_cost  <= i_cfg_data;
                stgse_pkg::REG_HOVER:  r_cfg.hover_cost <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stgse_obs_mem #(
        .GRID_SIDE (GRID_SIDE)
    ) u_obs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && i_cmd.command == stgse_pkg::CMD_OBS),
        .i_wr_item  (i_cmd),
        .i_rd       (obs_rd),
        .o_rd_bit   (obs_bit),
        .o_clr_busy (clr_busy)
    );

    stgse_path_store #(
        .MAX_PATHS  (MAX_PATHS),
        .PATH_DEPTH (PATH_DEPTH)
    ) u_paths (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && i_cmd.command == stgse_pkg::CMD_PATH),
        .i_wr_item  (i_cmd),
        .i_rd       (path_rd),
        .i_len_path (len_path),
        .o_rd_point (point),
        .o_len      (len)
    );

    stgse_expand_ctl #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_PATHS  (MAX_PATHS),
        .PATH_DEPTH (PATH_DEPTH),
        .WINDOW     (WINDOW)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_exp (accept && i_cmd.command == stgse_pkg::CMD_EXPAND),
        .i_item      (i_cmd),
        .i_cfg       (r_cfg),
        .i_obs_bit   (obs_bit),
        .i_point     (point),
        .i_len       (len),
        .o_obs_rd    (obs_rd),
        .o_path_rd   (path_rd),
        .o_len_path  (len_path),
        .o_busy      (seq_busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
